FILE: hw/rtl/named_entry_directory_table_top_defines.svh
// Assertion macros for the named entry directory table.
// Included by named_entry_directory_table_top.sv; no other dependencies.
`ifndef NAMED_ENTRY_DIRECTORY_TABLE_TOP_DEFINES_SVH
`define NAMED_ENTRY_DIRECTORY_TABLE_TOP_DEFINES_SVH

// Implication check, disabled during reset.
`define NEDT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition that must never be seen outside reset.
`define NEDT_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/nedt_pkg.sv
// Types and constants for the named entry directory table.
// No dependencies.
package nedt_pkg;

   typedef enum logic [2:0] {
      OP_FIND   = 3'd0,
      OP_CREATE = 3'd1,
      OP_DELETE = 3'd2,
      OP_RENAME = 3'd3,
      OP_UPDATE = 3'd4,
      OP_GET    = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ,
      ST_EXEC
   } state_type;

   localparam logic        STATUS_OK   = 1'b0;
   localparam logic        STATUS_FAIL = 1'b1;
   localparam logic [15:0] NO_BLOCK    = 16'hFFFF;

endpackage

FILE: hw/rtl/named_entry_directory_table_top.sv
// Named entry directory table: find, create, delete, rename, update, get.
// Depends on nedt_pkg and named_entry_directory_table_top_defines.svh.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | op, key_name, new_name, new_size,
//          |           |                      | new_first_block, slot_index
//  rsp     | out       | rsp_valid/rsp_ready  | status, slot, entry_name,
//          |           |                      | entry_size, entry_first_block
//
// One request at a time; req_ready is high only while the sequencer is idle.
// Find, create, delete and update walk the table once; rename walks it for the
// new name and then, if absent, for the old one; get reads its slot directly. The
// sequencer returns to idle before the next request is taken. The walk reads one
// slot a cycle through the single name memory read port and one name comparator.
// Reset clears the used marks at once; no clearing pass is needed.
// The result register lets the next request enter while rsp is stalled; a
// finished request waits in its last state until the result register frees.
`include "named_entry_directory_table_top_defines.svh"

module named_entry_directory_table_top #(
   parameter int ENTRIES    = 16,
   parameter int NAME_BYTES = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_op,
   input  logic [63:0]        req_key_name,
   input  logic [63:0]        req_new_name,
   input  logic [31:0]        req_new_size,
   input  logic signed [15:0] req_new_first_block,
   input  logic [3:0]         req_slot_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_status,
   output logic [3:0]         rsp_slot,
   output logic [63:0]        rsp_entry_name,
   output logic [31:0]        rsp_entry_size,
   output logic signed [15:0] rsp_entry_first_block
);
   import nedt_pkg::*;

   localparam int NAME_W = 8 * NAME_BYTES;
   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(ENTRIES);

   // storage
   logic [NAME_W-1:0] name_mem  [ENTRIES];
   logic [31:0]       size_mem  [ENTRIES];
   logic [15:0]       block_mem [ENTRIES];
   logic [ENTRIES-1:0] used_ff;

   state_type         state_ff, state_in;
   logic [2:0]        op_ff, op_in;
   logic [NAME_W-1:0] key_ff, key_in;
   logic [NAME_W-1:0] nname_ff, nname_in;
   logic [31:0]       size_ff, size_in;
   logic [15:0]       block_ff, block_in;
   logic [3:0]        idx_ff, idx_in;
   logic [NAME_W-1:0] target_ff, target_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic              free_ff, free_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic              pass_ff, pass_in;

   logic [NAME_W-1:0] rd_name_ff;
   logic [31:0]       rd_size_ff;
   logic [15:0]       rd_block_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_status_ff, rsp_status_in;
   logic [3:0]        rsp_slot_ff, rsp_slot_in;
   logic [63:0]       rsp_name_ff, rsp_name_in;
   logic [31:0]       rsp_size_ff, rsp_size_in;
   logic [15:0]       rsp_block_ff, rsp_block_in;

   // control
   logic              accept;
   logic              issue;
   logic [IDX_W-1:0]  scan_idx;
   logic              match;
   logic              scan_done;
   logic              restart;
   logic              out_free;
   logic [IDX_W-1:0]  get_addr;
   logic              get_ok;

   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              out_load;
   logic              exec_ok;
   logic [IDX_W-1:0]  exec_slot;
   logic              name_we, size_we, block_we;
   logic [IDX_W-1:0]  wr_addr;
   logic [NAME_W-1:0] name_wd;
   logic [31:0]       size_wd;
   logic [15:0]       block_wd;
   logic              used_we, used_wd;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign issue     = (state_ff == ST_SCAN) && (scan_ff < SCAN_END);
   assign scan_idx  = scan_ff[IDX_W-1:0];
   assign match     = pipe_vld_ff && used_ff[cmp_idx_ff] && (rd_name_ff == target_ff);
   assign scan_done = (state_ff == ST_SCAN) && !issue && !pipe_vld_ff;
   // rename: first walk looks for the new name, second for the old one
   assign restart   = scan_done && (op_ff == OP_RENAME) && !pass_ff && !hit_ff;

   assign get_addr  = IDX_W'(idx_ff);
   assign get_ok    = (32'(idx_ff) < 32'(ENTRIES)) && used_ff[get_addr];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (req_op == OP_GET) state_in = ST_READ;
               else if (req_op == OP_FIND || req_op == OP_CREATE || req_op == OP_DELETE ||
                        req_op == OP_RENAME || req_op == OP_UPDATE) state_in = ST_SCAN;
               else state_in = ST_EXEC;
            end
         end
         ST_SCAN: begin
            if (scan_done && !restart) state_in = ST_EXEC;
         end
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outcome of the request, evaluated in the exec state
   always_comb begin
      exec_ok   = 1'b0;
      exec_slot = hit_idx_ff;
      unique case (op_ff)
         OP_FIND:   exec_ok = hit_ff;
         OP_CREATE: begin
            exec_ok   = !hit_ff && free_ff;
            exec_slot = free_idx_ff;
         end
         OP_DELETE: exec_ok = hit_ff;
         OP_RENAME: exec_ok = pass_ff && hit_ff;
         OP_UPDATE: exec_ok = hit_ff;
         OP_GET: begin
            exec_ok   = get_ok;
            exec_slot = get_addr;
         end
         default:   exec_ok = 1'b0;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      rd_en    = 1'b0;
      rd_addr  = scan_idx;
      out_load = 1'b0;
      name_we  = 1'b0;
      size_we  = 1'b0;
      block_we = 1'b0;
      used_we  = 1'b0;
      used_wd  = 1'b0;
      wr_addr  = exec_slot;
      name_wd  = key_ff;
      size_wd  = size_ff;
      block_wd = block_ff;
      unique case (state_ff)
         ST_IDLE: ;
         ST_SCAN: rd_en = issue;
         ST_READ: begin
            rd_en   = 1'b1;
            rd_addr = get_addr;
         end
         ST_EXEC: begin
            if (out_free) begin
               out_load = 1'b1;
               if (exec_ok) begin
                  unique case (op_ff)
                     OP_CREATE: begin
                        used_we  = 1'b1;
                        used_wd  = 1'b1;
                        name_we  = 1'b1;
                        size_we  = 1'b1;
                        block_we = 1'b1;
                        size_wd  = 32'd0;
                        block_wd = NO_BLOCK;
                     end
                     OP_DELETE: used_we = 1'b1;
                     OP_RENAME: begin
                        name_we = 1'b1;
                        name_wd = nname_ff;
                     end
                     OP_UPDATE: begin
                        size_we  = 1'b1;
                        block_we = 1'b1;
                     end
                     default: ;
                  endcase
               end
            end
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      op_in       = op_ff;
      key_in      = key_ff;
      nname_in    = nname_ff;
      size_in     = size_ff;
      block_in    = block_ff;
      idx_in      = idx_ff;
      target_in   = target_ff;
      scan_in     = scan_ff;
      pipe_vld_in = issue;
      cmp_idx_in  = scan_idx;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      pass_in     = pass_ff;
      if (accept) begin
         op_in     = req_op;
         key_in    = req_key_name[NAME_W-1:0];
         nname_in  = req_new_name[NAME_W-1:0];
         size_in   = req_new_size;
         block_in  = req_new_first_block;
         idx_in    = req_slot_index;
         target_in = (req_op == OP_RENAME) ? req_new_name[NAME_W-1:0]
                                           : req_key_name[NAME_W-1:0];
         scan_in   = '0;
         hit_in    = 1'b0;
         free_in   = 1'b0;
         pass_in   = 1'b0;
      end else begin
         if (issue) begin
            scan_in = scan_ff + CNT_W'(1);
            if (!used_ff[scan_idx] && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = scan_idx;
            end
         end
         // lowest matching slot wins
         if (match && !hit_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = cmp_idx_ff;
         end
         if (restart) begin
            pass_in   = 1'b1;
            scan_in   = '0;
            hit_in    = 1'b0;
            target_in = key_ff;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_name_in   = rsp_name_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_block_in  = rsp_block_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = exec_ok ? STATUS_OK : STATUS_FAIL;
         rsp_slot_in   = exec_ok ? 4'(exec_slot) : 4'd0;
         rsp_name_in   = '0;
         rsp_size_in   = '0;
         rsp_block_in  = '0;
         if (exec_ok && op_ff == OP_GET) begin
            rsp_name_in  = 64'(rd_name_ff);
            rsp_size_in  = rd_size_ff;
            rsp_block_in = rd_block_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pipe_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         pipe_vld_ff  <= pipe_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (used_we) used_ff[wr_addr] <= used_wd;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      nname_ff      <= nname_in;
      size_ff       <= size_in;
      block_ff      <= block_in;
      idx_ff        <= idx_in;
      target_ff     <= target_in;
      scan_ff       <= scan_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      pass_ff       <= pass_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_name_ff   <= rsp_name_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_block_ff  <= rsp_block_in;
   end

   // entry memories: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (name_we)  name_mem[wr_addr]  <= name_wd;
      if (size_we)  size_mem[wr_addr]  <= size_wd;
      if (block_we) block_mem[wr_addr] <= block_wd;
      if (rd_en) begin
         rd_name_ff  <= name_mem[rd_addr];
         rd_size_ff  <= size_mem[rd_addr];
         rd_block_ff <= block_mem[rd_addr];
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_slot              = rsp_slot_ff;
   assign rsp_entry_name        = rsp_name_ff;
   assign rsp_entry_size        = rsp_size_ff;
   assign rsp_entry_first_block = rsp_block_ff;

   `NEDT_ASSERT_IMPL(a_write_in_exec, clock, reset, name_we || size_we || block_we || used_we, state_ff == ST_EXEC && out_free, "table write outside exec")
   `NEDT_ASSERT_IMPL(a_create_free_slot, clock, reset, used_we && used_wd, !used_ff[wr_addr], "create allocated a used slot")
   `NEDT_ASSERT_IMPL(a_hit_is_used, clock, reset, state_ff == ST_EXEC && hit_ff, used_ff[hit_idx_ff], "name hit on an unused slot")
   `NEDT_ASSERT_NEVER(a_load_when_full, clock, reset, out_load && rsp_valid_ff && !rsp_ready, "result overwritten while stalled")

endmodule
